// ===== hw/rtl/rdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W        = 64;
    localparam int DIGEST_W      = 4 * WORD_W;
    localparam int USED_W        = 7;
    localparam int STATUS_W      = 3;
    localparam int IN_DATA_W     = 2 * DIGEST_W;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 16;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_INVALID        = 3'd1,
        ST_DUPLICATE      = 3'd2,
        ST_FULL           = 3'd3,
        ST_TOKEN_REVOKED  = 3'd4,
        ST_ISSUER_REVOKED = 3'd5
    } status_t;

    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_ISSUER = 1'b1;

    typedef struct packed {
        logic                we;
        logic                clear_all;
        logic [IDX_W-1:0]    idx;
        logic                kind;
        logic [DIGEST_W-1:0] digest;
    } rdt_wr_t;

    typedef struct packed {
        logic                slot_valid;
        logic                kind;
        logic [DIGEST_W-1:0] digest;
    } rdt_row_t;

    typedef struct packed {
        logic is_add;
        logic is_check;
        logic kind;
    } rdt_cmp_ctl_t;

    typedef struct packed {
        logic dup_hit;
        logic token_hit;
        logic issuer_hit;
    } rdt_hit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rdt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdt_store
    import rdt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rdt_wr_t          wr,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output rdt_row_t              rd_row
);

    localparam int ROW_W = DIGEST_W + 1;

    logic [ROW_W-1:0]         mem [TABLE_ENTRIES];
    logic [ROW_W-1:0]         rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;

    // digest and kind storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.idx] <= {wr.kind, wr.digest};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_row.slot_valid = rd_valid_reg;
    assign rd_row.kind       = rd_data_reg[DIGEST_W];
    assign rd_row.digest     = rd_data_reg[DIGEST_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rdt_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdt_cmp
    import rdt_pkg::*;
(
    input  wire rdt_cmp_ctl_t        ctl,
    input  wire logic [DIGEST_W-1:0] primary,
    input  wire logic [DIGEST_W-1:0] issuer,
    input  wire rdt_row_t            row,
    output rdt_hit_t                 hit
);

    logic [DIGEST_W-1:0] target;
    logic                match;

    // one shared 256-bit compare; a check picks its operand by the row kind
    always_comb
    begin
        if (ctl.is_check && (row.kind == KIND_ISSUER))
        begin
            target = issuer;
        end
        else
        begin
            target = primary;
        end
        match = row.slot_valid && (row.digest == target);

        hit.dup_hit    = ctl.is_add && match && (row.kind == ctl.kind);
        hit.token_hit  = ctl.is_check && match && (row.kind == KIND_TOKEN);
        hit.issuer_hit = ctl.is_check && match && (row.kind == KIND_ISSUER);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/revocation_digest_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | signals                  | contents
// ---------+-----+--------------------------+-----------------------------------------
// request  | in  | s_tvalid s_tready        | s_tdata: primary w0..w3, issuer w0..w3
//          |     | s_tdata s_tuser          | s_tuser: req_type, entry_kind
// result   | out | m_tvalid m_tready m_tdata| m_tdata: status, entries_used
//
// add and check scan the whole table between one accepted transaction and the next:
// the single read port of the slot memory is scanned one slot a cycle through the
// shared digest compare, then a wait state drains the read and a finish state decides.
// clear and unused request types go straight to the finish state. no pass is needed after reset.
// a result held on m_tdata while m_tready is low stalls only the final step.

module revocation_digest_table
    import rdt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // primary w0..w3, issuer w0..w3
    input  wire logic [IN_USER_W-1:0]  s_tuser,  // req_type[1:0], entry_kind
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata   // status[2:0], entries_used[6:0], zeros
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic                kind_reg, kind_next;
    logic [DIGEST_W-1:0] prim_reg, prim_next;
    logic [DIGEST_W-1:0] iss_reg, iss_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                dup_reg, dup_next;
    logic                tok_reg, tok_next;
    logic                isshit_reg, isshit_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [USED_W-1:0]   m_used_reg, m_used_next;

    rdt_wr_t      wr;
    rdt_row_t     row;
    rdt_cmp_ctl_t cmp_ctl;
    rdt_hit_t     hit;
    logic         rd_en;
    logic         out_free;
    logic         prim_zero;
    logic         iss_zero;
    status_t      fin_status;
    logic         fin_write;
    logic         fin_clear;

    rdt_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_en  (rd_en),
        .rd_idx (scan_idx_reg),
        .rd_row (row)
    );

    assign cmp_ctl.is_add   = (req_reg == REQ_ADD);
    assign cmp_ctl.is_check = (req_reg == REQ_CHECK);
    assign cmp_ctl.kind     = kind_reg;

    rdt_cmp u_cmp (
        .ctl     (cmp_ctl),
        .primary (prim_reg),
        .issuer  (iss_reg),
        .row     (row),
        .hit     (hit)
    );

    assign prim_zero = ~|prim_reg;
    assign iss_zero  = ~|iss_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // outcome of the finished request (after the scan for add and check)
    always_comb
    begin
        fin_status = ST_OK;
        fin_write  = 1'b0;
        fin_clear  = 1'b0;
        case (req_reg)
            REQ_CLEAR:
            begin
                fin_clear = 1'b1;
            end
            REQ_ADD:
            begin
                if (prim_zero)
                begin
                    fin_status = ST_INVALID;
                end
                else if (dup_reg)
                begin
                    fin_status = ST_DUPLICATE;
                end
                else if ((count_reg >= CNT_W'(TABLE_ENTRIES)) || !free_found_reg)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_write = 1'b1;
                end
            end
            REQ_CHECK:
            begin
                if (prim_zero || iss_zero)
                begin
                    fin_status = ST_INVALID;
                end
                else if (tok_reg)
                begin
                    fin_status = ST_TOKEN_REVOKED;
                end
                else if (isshit_reg)
                begin
                    fin_status = ST_ISSUER_REVOKED;
                end
            end
            default:
            begin
                fin_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        kind_next       = kind_reg;
        prim_next       = prim_reg;
        iss_next        = iss_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = scan_idx_reg;
        dup_next        = dup_reg;
        tok_next        = tok_reg;
        isshit_next     = isshit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_used_next     = m_used_reg;
        rd_en           = 1'b0;
        wr.we           = 1'b0;
        wr.clear_all    = 1'b0;
        wr.idx          = free_idx_reg;
        wr.kind         = kind_reg;
        wr.digest       = prim_reg;

        // gather compare results in the cycle after the read
        if (pend_reg)
        begin
            dup_next    = dup_reg || hit.dup_hit;
            tok_next    = tok_reg || hit.token_hit;
            isshit_next = isshit_reg || hit.issuer_hit;
            if (!row.slot_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pend_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = req_t'(s_tuser[1:0]);
                    kind_next       = s_tuser[2];
                    prim_next       = s_tdata[DIGEST_W-1:0];
                    iss_next        = s_tdata[IN_DATA_W-1:DIGEST_W];
                    scan_idx_next   = '0;
                    dup_next        = 1'b0;
                    tok_next        = 1'b0;
                    isshit_next     = 1'b0;
                    free_found_next = 1'b0;
                    if ((req_t'(s_tuser[1:0]) == REQ_ADD) ||
                        (req_t'(s_tuser[1:0]) == REQ_CHECK))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    wr.we        = fin_write;
                    wr.clear_all = fin_clear;
                    if (fin_clear)
                    begin
                        count_next = '0;
                    end
                    else if (fin_write)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    m_valid_next  = 1'b1;
                    m_status_next = fin_status;
                    m_used_next   = USED_W'(count_next);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        kind_reg       <= kind_next;
        prim_reg       <= prim_next;
        iss_reg        <= iss_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        dup_reg        <= dup_next;
        tok_reg        <= tok_next;
        isshit_reg     <= isshit_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        m_status_reg   <= m_status_next;
        m_used_reg     <= m_used_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - USED_W - STATUS_W)'(0), m_used_reg, m_status_reg};

endmodule

`default_nettype wire
